### sv/bpcr_pkg.sv
// Shared types, codes and helpers for the box push-out collision resolver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bpcr_pkg;

    // Field widths (Q11.4 coordinates, unsigned half sizes)
    localparam int COORD_W   = 16;
    localparam int HALF_W    = 15;
    localparam int SUM_W     = HALF_W + 1;
    localparam int EXT_W     = COORD_W + 2;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = HALF_W;

    // Action codes of an input item
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WALL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PLATE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;

    localparam logic [HALF_W-1:0] HALF_RESET = 15'd160;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

    // Item class decided by the front
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_WALL  = 2'd1,
        OP_PLATE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Classified item as held in the queue
    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  obj_x;
        logic signed [COORD_W-1:0]  obj_y;
        logic [SUM_W-1:0]           sum_w;
        logic [SUM_W-1:0]           sum_h;
        logic signed [COORD_W-1:0]  left_x;
        logic signed [COORD_W-1:0]  right_x;
        logic signed [COORD_W-1:0]  top_y;
        logic signed [COORD_W-1:0]  bot_y;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      hit;
        logic                      landed;
        logic                      launched;
    } t_res;

    // Clamp an extended coordinate to the 16-bit range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(COORD_MAX);
        lo = EXT_W'(COORD_MIN);
        if (v > hi) begin
            return COORD_MAX;
        end else if (v < lo) begin
            return COORD_MIN;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/bpcr_if.sv
// Valid/ready channel interfaces: input items, result items, config writes.
// Depends on bpcr_pkg for field widths.
`default_nettype none

interface bpcr_item_if import bpcr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic signed [COORD_W-1:0]  obj_x;
    logic signed [COORD_W-1:0]  obj_y;
    logic [HALF_W-1:0]          obj_half_w;
    logic [HALF_W-1:0]          obj_half_h;

    modport source (output valid, action, obj_x, obj_y, obj_half_w, obj_half_h,
                    input ready);
    modport sink   (input valid, action, obj_x, obj_y, obj_half_w, obj_half_h,
                    output ready);
endinterface

interface bpcr_res_if import bpcr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic                       hit;
    logic                       landed;
    logic                       launched;

    modport source (output valid, pos_x, pos_y, hit, landed, launched,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, hit, landed, launched,
                    output ready);
endinterface

interface bpcr_cfg_if import bpcr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/box_pushout_collision_resolver.sv
// Top level of the box push-out collision resolver: front, queue and back.
// Depends on bpcr_pkg, bpcr_if, bpcr_front, bpcr_fifo and bpcr_back.
`default_nettype none

// Channel   Dir  Handshake        Payload
// i_item    in   valid / ready    action, obj_x, obj_y, obj_half_w, obj_half_h
// o_res     out  valid / ready    pos_x, pos_y, hit, landed, launched
// i_cfg     in   valid / ready    index (0 half width, 1 half height), data
//
// One item per cycle sustained while results are taken; an accepted item is
// registered first in the queue, then in the back-end output register.
// The rate is set by the back end's position update, which needs the previous position.
// Reset clears the position to zero, the half sizes to 160 and the queue.
// A stalled result holds the back end; the two-entry queue absorbs items
// until full, then input ready drops.

module box_pushout_collision_resolver import bpcr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bpcr_item_if.sink   i_item,
    bpcr_cfg_if.sink    i_cfg,
    bpcr_res_if.source  o_res
);

    // Front to queue
    logic q_push;
    logic q_ready;
    t_cmd q_cmd;

    // Queue to back
    logic b_valid;
    logic b_pop;
    t_cmd b_cmd;

    // Accept, classify and precompute terms that do not depend on the mover position
    bpcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (q_cmd)
    );

    // Decouple the two sides so each can stall on its own
    bpcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_ready (q_ready),
        .o_valid (b_valid),
        .o_cmd   (b_cmd),
        .i_pop   (b_pop)
    );

    // Resolve against the stored position and register the result
    bpcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .i_cmd   (b_cmd),
        .o_pop   (b_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### sv/bpcr_front.sv
// Front end: holds the mover half sizes, accepts items, classifies them and
// precomputes summed half sizes and clamped push targets. Uses bpcr_pkg.
`default_nettype none

module bpcr_front import bpcr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bpcr_item_if.sink   i_item,
    bpcr_cfg_if.sink    i_cfg,
    input  wire logic   i_q_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [HALF_W-1:0] r_half_w;
    logic [HALF_W-1:0] r_half_h;

    logic [SUM_W-1:0]          sum_w;
    logic [SUM_W-1:0]          sum_h;
    logic signed [EXT_W-1:0]   ox_ext;
    logic signed [EXT_W-1:0]   oy_ext;
    logic signed [EXT_W-1:0]   sw_ext;
    logic signed [EXT_W-1:0]   sh_ext;
    t_op                       op;

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= HALF_RESET;
            r_half_h <= HALF_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_HALF_WIDTH:  r_half_w <= i_cfg.data;
                REG_HALF_HEIGHT: r_half_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_item.action)
            ACT_LOAD:  op = OP_LOAD;
            ACT_WALL:  op = OP_WALL;
            ACT_PLATE: op = OP_PLATE;
            default:   op = OP_NOP;
        endcase
    end

    // Summed half sizes and the positions a push lands on
    assign sum_w  = SUM_W'(r_half_w) + SUM_W'(i_item.obj_half_w);
    assign sum_h  = SUM_W'(r_half_h) + SUM_W'(i_item.obj_half_h);
    assign ox_ext = EXT_W'(i_item.obj_x);
    assign oy_ext = EXT_W'(i_item.obj_y);
    assign sw_ext = $signed(EXT_W'(sum_w));
    assign sh_ext = $signed(EXT_W'(sum_h));

    always_comb begin
        o_cmd.op      = op;
        o_cmd.obj_x   = i_item.obj_x;
        o_cmd.obj_y   = i_item.obj_y;
        o_cmd.sum_w   = sum_w;
        o_cmd.sum_h   = sum_h;
        o_cmd.left_x  = sat_coord(ox_ext - sw_ext);
        o_cmd.right_x = sat_coord(ox_ext + sw_ext);
        o_cmd.top_y   = sat_coord(oy_ext - sh_ext);
        o_cmd.bot_y   = sat_coord(oy_ext + sh_ext);
    end

    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid & i_q_ready;

endmodule

`default_nettype wire

### sv/bpcr_fifo.sv
// Short queue of classified items between front and back.
// Uses t_cmd and the queue sizes from bpcr_pkg.
`default_nettype none

module bpcr_fifo import bpcr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_cmd   i_cmd,
    output logic        o_ready,
    output logic        o_valid,
    output t_cmd        o_cmd,
    input  wire logic   i_pop
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    assign o_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/bpcr_back.sv
// Back end: holds the mover position, resolves one queued item per cycle against it
// unless the result is stalled, and registers the result. Uses bpcr_pkg.
`default_nettype none

module bpcr_back import bpcr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_pop,
    bpcr_res_if.source  o_res
);

    logic signed [COORD_W-1:0] r_mx, n_mx;
    logic signed [COORD_W-1:0] r_my, n_my;
    logic                      r_out_valid;
    t_res                      r_out;
    t_res                      n_out;

    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]         adx;
    logic [DIFF_W-1:0]         ady;
    logic                      fit_x;
    logic                      fit_y;
    logic                      horiz;

    assign o_pop = i_valid & (~r_out_valid | o_res.ready);

    assign dx    = DIFF_W'(r_mx) - DIFF_W'(i_cmd.obj_x);
    assign dy    = DIFF_W'(r_my) - DIFF_W'(i_cmd.obj_y);
    assign adx   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign ady   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    // Depth >= 0 on an axis reduces to the offset fitting the summed halves
    assign fit_x = (adx <= DIFF_W'(i_cmd.sum_w));
    assign fit_y = (ady <= DIFF_W'(i_cmd.sum_h));
    assign horiz = (ady < adx);

    always_comb begin
        n_mx           = r_mx;
        n_my           = r_my;
        n_out.hit      = 1'b0;
        n_out.landed   = 1'b0;
        n_out.launched = 1'b0;
        case (i_cmd.op)
            OP_LOAD: begin
                n_mx = i_cmd.obj_x;
                n_my = i_cmd.obj_y;
            end
            OP_WALL: begin
                if (horiz) begin
                    if (dx != '0 && fit_x && fit_y) begin
                        n_mx      = dx[DIFF_W-1] ? i_cmd.left_x : i_cmd.right_x;
                        n_out.hit = 1'b1;
                    end
                end else if (dy != '0 && fit_x && fit_y) begin
                    n_my         = dy[DIFF_W-1] ? i_cmd.top_y : i_cmd.bot_y;
                    n_out.hit    = 1'b1;
                    n_out.landed = dy[DIFF_W-1];
                end
            end
            OP_PLATE: begin
                if (dy[DIFF_W-1] && fit_x && fit_y) begin
                    n_my           = i_cmd.top_y;
                    n_out.hit      = 1'b1;
                    n_out.launched = 1'b1;
                end
            end
            default: ;
        endcase
        n_out.pos_x = n_mx;
        n_out.pos_y = n_my;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mx        <= '0;
            r_my        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mx        <= n_mx;
                r_my        <= n_my;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.pos_x    = r_out.pos_x;
    assign o_res.pos_y    = r_out.pos_y;
    assign o_res.hit      = r_out.hit;
    assign o_res.landed   = r_out.landed;
    assign o_res.launched = r_out.launched;

endmodule

`default_nettype wire

### sv/bpcr_checker.sv
// Port-level checks for the box push-out collision resolver, bound to the
// top level. Depends on bpcr_pkg and box_pushout_collision_resolver.
`default_nettype none

module bpcr_checker import bpcr_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_item_valid,
    input wire logic                      i_item_ready,
    input wire logic                      i_res_valid,
    input wire logic                      i_res_ready,
    input wire logic signed [COORD_W-1:0] i_pos_x,
    input wire logic signed [COORD_W-1:0] i_pos_y,
    input wire logic                      i_hit,
    input wire logic                      i_landed,
    input wire logic                      i_launched
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_pos_x)
            && $stable(i_pos_y) && $stable(i_hit) && $stable(i_landed)
            && $stable(i_launched))
        else $error("stalled result changed");

    // Landing and launch only come with a push, never both at once
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (!i_landed || i_hit) && (!i_launched || i_hit)
            && !(i_landed && i_launched))
        else $error("inconsistent hit flags");

    // Input backpressure only follows a stalled output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item_ready |-> $past(i_res_valid && !i_res_ready))
        else $error("input stalled without output stall");

    // A fresh result follows an accepted item, through the queue and the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_item_valid && i_item_ready, 2))
        else $error("result without matching item");

endmodule

bind box_pushout_collision_resolver bpcr_checker u_bpcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item.valid),
    .i_item_ready (i_item.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_pos_x      (o_res.pos_x),
    .i_pos_y      (o_res.pos_y),
    .i_hit        (o_res.hit),
    .i_landed     (o_res.landed),
    .i_launched   (o_res.launched)
);

`default_nettype wire

### verif/tb_box_pushout_collision_resolver.sv
// Self-checking testbench for box_pushout_collision_resolver: directed cases, then random traffic.
// Depends on bpcr_pkg, the channel interfaces in bpcr_if and the RTL of the block.

module tb_box_pushout_collision_resolver;
    import bpcr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    // Quiet wait after the block has drained, before any write or the end of the run
    localparam int DRAIN_CYCLES = 4;
    localparam int RUN_LIMIT    = 400000;

    // Action code the block treats as a no-op
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [COORD_W-1:0] obj_x;
        logic signed [COORD_W-1:0] obj_y;
        logic [HALF_W-1:0]         half_w;
        logic [HALF_W-1:0]         half_h;
    } t_obstacle;

    logic i_clk;
    logic i_rst_n;

    bpcr_item_if item_if ();
    bpcr_res_if  res_if ();
    bpcr_cfg_if  cfg_if ();

    box_pushout_collision_resolver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Mover position and half sizes as the block should hold them
    logic signed [COORD_W-1:0] track_x    = '0;
    logic signed [COORD_W-1:0] track_y    = '0;
    logic [HALF_W-1:0]         half_w_cfg = 15'd160;
    logic [HALF_W-1:0]         half_h_cfg = 15'd160;

    // Expected positions and flags, oldest first
    t_res pending_pos[$];

    int error_count = 0;
    int cycle_count = 0;
    bit idle_on     = 1'b0;
    bit stall_on    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hold the run to a bound; a hang counts as a failure
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Gap length: one time in ten from the long range, else from the short range
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[COORD_W-1:0];
    endfunction

    // Resolve one obstacle against the tracked mover and advance the tracked position
    function automatic t_res predict_push(input t_obstacle ob);
        int   mx, my, mw, mh, ox, oy, ow, oh;
        int   dx, dy, adx, ady, depth;
        t_res r;
        mx = int'(track_x);
        my = int'(track_y);
        mw = int'(half_w_cfg);
        mh = int'(half_h_cfg);
        ox = int'(ob.obj_x);
        oy = int'(ob.obj_y);
        ow = int'(ob.half_w);
        oh = int'(ob.half_h);
        dx = mx - ox;
        dy = my - oy;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        r = '0;
        case (ob.action)
            ACT_LOAD: begin
                track_x = ob.obj_x;
                track_y = ob.obj_y;
            end
            ACT_WALL: begin
                // Horizontal axis only when the vertical offset is strictly smaller
                if (ady < adx) begin
                    if (dx < 0) begin
                        depth = (mx + mw) - (ox - ow);
                        if (depth >= 0 && ady <= mh + oh) begin
                            track_x = clamp_coord(mx - depth);
                            r.hit   = 1'b1;
                        end
                    end else if (dx > 0) begin
                        depth = (ox + ow) - (mx - mw);
                        if (depth >= 0 && ady <= mh + oh) begin
                            track_x = clamp_coord(mx + depth);
                            r.hit   = 1'b1;
                        end
                    end
                end else begin
                    if (dy < 0) begin
                        depth = (my + mh) - (oy - oh);
                        if (depth >= 0 && adx <= mw + ow) begin
                            track_y  = clamp_coord(my - depth);
                            r.hit    = 1'b1;
                            r.landed = 1'b1;
                        end
                    end else if (dy > 0) begin
                        depth = (oy + oh) - (my - mh);
                        if (depth >= 0 && adx <= mw + ow) begin
                            track_y = clamp_coord(my + depth);
                            r.hit   = 1'b1;
                        end
                    end
                end
            end
            ACT_PLATE: begin
                // Plates only catch a mover that sits above them
                if (dy < 0) begin
                    depth = (my + mh) - (oy - oh);
                    if (depth >= 0 && adx <= mw + ow) begin
                        track_y    = clamp_coord(my - depth);
                        r.hit      = 1'b1;
                        r.launched = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.pos_x = track_x;
        r.pos_y = track_y;
        return r;
    endfunction

    // Drive one item at the falling edge, hold it until accepted, record the expectation.
    // Returns at the falling edge after acceptance with valid still high; the next
    // caller either replaces the item or drops valid in that same step.
    task automatic push_obstacle(input logic [ACT_W-1:0] act, input int x, input int y,
                                 input int w, input int h);
        t_obstacle ob;
        int        gap;
        t_res      want_res;
        ob.action = act;
        ob.obj_x  = x[COORD_W-1:0];
        ob.obj_y  = y[COORD_W-1:0];
        ob.half_w = w[HALF_W-1:0];
        ob.half_h = h[HALF_W-1:0];
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.action     <= ob.action;
        item_if.obj_x      <= ob.obj_x;
        item_if.obj_y      <= ob.obj_y;
        item_if.obj_half_w <= ob.half_w;
        item_if.obj_half_h <= ob.half_h;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        want_res    = predict_push(ob);
        pending_pos = {pending_pos, want_res};
        @(negedge i_clk);
    endtask

    // Write a register once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        item_if.valid <= 1'b0;
        while (pending_pos.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[HALF_W-1:0];
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        if (idx == REG_HALF_WIDTH) begin
            half_w_cfg = value[HALF_W-1:0];
        end else if (idx == REG_HALF_HEIGHT) begin
            half_h_cfg = value[HALF_W-1:0];
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Result side: stall at random, with stretches of steady ready when stalls are off
    initial begin : ready_gen
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                hold = pick_gap() - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_pos.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual x=%0d y=%0d",
                         $time, res_if.pos_x, res_if.pos_y);
            end else begin
                want = pending_pos.pop_front();
                check_field("pos_x", 32'(want.pos_x), 32'(res_if.pos_x));
                check_field("pos_y", 32'(want.pos_y), 32'(res_if.pos_y));
                check_field("hit", 32'(want.hit), 32'(res_if.hit));
                check_field("landed", 32'(want.landed), 32'(res_if.landed));
                check_field("launched", 32'(want.launched), 32'(res_if.launched));
            end
        end
    end

    // Position zero and default half sizes of 160 right after reset
    task automatic test_reset_values();
        push_obstacle(ACT_NONE, -1, -1, 32'h7fff, 32'h7fff);
        push_obstacle(ACT_WALL, 300, 0, 160, 160);
    endtask

    // Load the coordinate extremes; obstacle sizes must not matter
    task automatic test_load_extremes();
        push_obstacle(ACT_LOAD, 32767, -32768, 32'h7fff, 0);
        push_obstacle(ACT_LOAD, -32768, 32767, 0, 32'h7fff);
        push_obstacle(ACT_LOAD, 0, 0, 0, 0);
    endtask

    // Walls from each side, coincident centers, the diagonal tie, a miss on the
    // cross axis, and exact touching versus one step apart
    task automatic test_wall_sides();
        push_obstacle(ACT_WALL, -300, 0, 160, 160);
        push_obstacle(ACT_WALL, 20, 300, 160, 160);
        push_obstacle(ACT_WALL, 20, -320, 160, 160);
        push_obstacle(ACT_WALL, 20, 0, 50, 50);
        push_obstacle(ACT_WALL, 220, 200, 160, 160);
        push_obstacle(ACT_WALL, 420, 80, 300, 10);
        push_obstacle(ACT_WALL, 340, -120, 160, 160);
        push_obstacle(ACT_WALL, 341, -120, 160, 160);
    endtask

    // Plate pushes from above only, and needs horizontal overlap
    task automatic test_plate();
        push_obstacle(ACT_PLATE, 20, 180, 160, 160);
        push_obstacle(ACT_PLATE, 20, -440, 160, 160);
        push_obstacle(ACT_PLATE, 400, 0, 100, 100);
    endtask

    // Pushes that run past the coordinate range clamp at both ends
    task automatic test_saturation();
        push_obstacle(ACT_LOAD, 32000, 0, 0, 0);
        push_obstacle(ACT_WALL, 31000, 0, 32'h7fff, 0);
        push_obstacle(ACT_LOAD, 0, -32000, 0, 0);
        push_obstacle(ACT_WALL, 0, -31000, 0, 32'h7fff);
    endtask

    // Unmapped indexes are dropped; half sizes at their extremes
    task automatic test_config_regs();
        write_reg(REG_SPARE_LO, 32'h7fff);
        write_reg(REG_SPARE_HI, 0);
        write_reg(REG_HALF_WIDTH, 0);
        write_reg(REG_HALF_HEIGHT, 32767);
        push_obstacle(ACT_LOAD, 0, 0, 0, 0);
        push_obstacle(ACT_WALL, 5, 2000, 5, 0);
        write_reg(REG_HALF_WIDTH, 32767);
        write_reg(REG_HALF_HEIGHT, 0);
        push_obstacle(ACT_WALL, 3000, 0, 0, 0);
    endtask

    // Random traffic in six phases, each with its own half sizes; two change the idle pattern.
    // Most obstacles land near the mover so pushes are frequent.
    task automatic test_random_traffic(input int n_items);
        int               per_phase;
        int               ph;
        int               n;
        int               roll;
        int               w;
        int               h;
        int               ow;
        int               oh;
        int               sx;
        int               sy;
        int               ox;
        int               oy;
        logic [ACT_W-1:0] act;
        per_phase = n_items / 6;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    w = 0;
                    h = 32767;
                end
                1: begin
                    w = 32767;
                    h = 0;
                end
                2: begin
                    w = 0;
                    h = 0;
                end
                default: begin
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(0, 400);
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(0, 400);
                end
            endcase
            write_reg(REG_HALF_WIDTH, w);
            write_reg(REG_HALF_HEIGHT, h);
            // Leave one phase without sender gaps and one without result stalls
            idle_on  = (ph != 3);
            stall_on = (ph != 4);
            for (n = 0; n < per_phase; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 7) begin
                    if ($urandom_range(0, 7) == 0) begin
                        push_obstacle(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
                    end else begin
                        push_obstacle(ACT_LOAD, int'($urandom_range(0, 6000)) - 3000,
                                      int'($urandom_range(0, 6000)) - 3000, 0, 0);
                    end
                end else if (roll < 13) begin
                    // Noise: any code, any field value
                    push_obstacle(ACT_W'($urandom_range(ACT_LOAD, ACT_NONE)), $urandom,
                                  $urandom, $urandom, $urandom);
                end else begin
                    ow = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 400);
                    oh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 400);
                    sx = int'(half_w_cfg) + ow + 48;
                    sy = int'(half_h_cfg) + oh + 48;
                    ox = int'(clamp_coord(track_x + int'($urandom_range(0, 2 * sx)) - sx));
                    oy = int'(clamp_coord(track_y + int'($urandom_range(0, 2 * sy)) - sy));
                    if (roll < 35) begin
                        act = ACT_PLATE;
                    end else if (roll < 38) begin
                        act = ACT_NONE;
                    end else begin
                        act = ACT_WALL;
                    end
                    push_obstacle(act, ox, oy, ow, oh);
                end
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.action     = ACT_LOAD;
        item_if.obj_x      = '0;
        item_if.obj_y      = '0;
        item_if.obj_half_w = '0;
        item_if.obj_half_h = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_HALF_WIDTH;
        cfg_if.data        = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_on  = 1'b1;
        stall_on = 1'b1;
        test_reset_values();
        test_load_extremes();
        test_wall_sides();
        test_plate();
        test_saturation();
        test_config_regs();
        test_random_traffic(1050);

        // Drain: drop valid, wait for every result, then DRAIN_CYCLES quiet cycles
        item_if.valid <= 1'b0;
        while (pending_pos.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
